// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the barometric compensation unit
// Register map codes, saturation bounds and the limb width of the wide
// multipliers.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int LIMB_W = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int CAL_HI_W = 40;
  localparam int CAL_W = 168;

  typedef enum logic [1:0] {
    REG_LO  = 2'd0,
    REG_MID = 2'd1,
    REG_HI  = 2'd2
  } reg_sel_t;

  localparam logic signed [23:0] T_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] T_MIN = -24'sh800000;
  localparam logic [22:0] P_MAX = 23'h7FFFFF;

endpackage

// File: rtl/bpc_hstep.sv
// ----------------------------------------------------------------------------
// bpc_hstep: one Horner step of the pressure polynomial
// Computes h_out = b + tn * h exactly in five stages: magnitudes, 32x32
// partial products, row sums, row combine, signed accumulate.
// ----------------------------------------------------------------------------
module bpc_hstep #(
  parameter int TN_W = 45,
  parameter int HI_W = 34,
  parameter int HO_W = 79,
  parameter int SB_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [TN_W-1:0] in_tn,
  input  logic signed [HI_W-1:0] in_h,
  input  logic signed [HO_W-1:0] in_b,
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [TN_W-1:0] out_tn,
  output logic signed [HO_W-1:0] out_h,
  output logic [SB_W-1:0]        out_sb
);

  localparam int LW = bpc_pkg::LIMB_W;
  localparam int NA = (TN_W + LW - 1) / LW;
  localparam int NB = (HI_W + LW - 1) / LW;
  localparam int AW = NA * LW;
  localparam int BW = NB * LW;
  localparam int PPW = 2 * LW;
  localparam int RW = (NB + 1) * LW;
  localparam int PW = (NA + NB) * LW;
  localparam int NST = 5;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic [TN_W-1:0] tn_abs;
  logic [HI_W-1:0] h_abs;
  logic [AW-1:0]   tm_r;
  logic [BW-1:0]   hm_r;
  logic [PPW-1:0]  pp_nxt [NA][NB];
  logic [PPW-1:0]  pp_r [NA][NB];
  logic [RW-1:0]   row_nxt [NA];
  logic [RW-1:0]   row_r [NA];
  logic [PW-1:0]   prod_nxt;
  logic [PW-1:0]   prod_r;
  logic [HO_W-1:0] h_nxt;
  logic [HO_W-1:0] h_r;

  logic [TN_W-1:0] tn_r [NST];
  logic [SB_W-1:0] sb_r [NST];
  logic [HO_W-1:0] b_r [NST-1];
  logic            neg_r [NST-1];

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign tn_abs = in_tn[TN_W-1] ? $unsigned(-in_tn) : $unsigned(in_tn);
  assign h_abs  = in_h[HI_W-1] ? $unsigned(-in_h) : $unsigned(in_h);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = PPW'(tm_r[i*LW +: LW]) * PPW'(hm_r[j*LW +: LW]);
      end
    end
  end

  always_comb begin
    logic [RW-1:0] lo;
    logic [RW-1:0] hi;
    for (int i = 0; i < NA; i++) begin
      lo = '0;
      hi = '0;
      for (int j = 0; j < NB; j++) begin
        lo[j*LW +: LW]     = pp_r[i][j][LW-1:0];
        hi[(j+1)*LW +: LW] = pp_r[i][j][PPW-1:LW];
      end
      row_nxt[i] = lo + hi;
    end
  end

  always_comb begin
    prod_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      prod_nxt = prod_nxt + (PW'(row_r[i]) << (i * LW));
    end
  end

  assign h_nxt = neg_r[NST-2] ? b_r[NST-2] - prod_r[HO_W-1:0]
                              : b_r[NST-2] + prod_r[HO_W-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tm_r     <= AW'(tn_abs);
      hm_r     <= BW'(h_abs);
      neg_r[0] <= in_tn[TN_W-1] ^ in_h[HI_W-1];
      tn_r[0]  <= in_tn;
      b_r[0]   <= in_b;
      sb_r[0]  <= in_sb;
    end
    if (en[1]) begin
      pp_r <= pp_nxt;
    end
    if (en[2]) begin
      row_r <= row_nxt;
    end
    if (en[3]) begin
      prod_r <= prod_nxt;
    end
    if (en[4]) begin
      h_r <= h_nxt;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        tn_r[k] <= tn_r[k-1];
        sb_r[k] <= sb_r[k-1];
      end
    end
    for (int k = 1; k < NST - 1; k++) begin
      if (en[k]) begin
        b_r[k]   <= b_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign out_tn = $signed(tn_r[NST-1]);
  assign out_h  = $signed(h_r);
  assign out_sb = sb_r[NST-1];

endmodule

// File: rtl/baro_pressure_temp_compensation_unit.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit: temperature and pressure compensation
// Unpacks 21 calibration bytes and evaluates the temperature quadratic and
// the cubic pressure polynomial in exact fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Load the three calibration words through the APB port (byte addresses
//   0, 8 and 16) while the unit is idle. Each input transaction carries one
//   raw temperature and one raw pressure reading; each produces exactly one
//   output transaction with the compensated temperature (1/65536 degC),
//   pressure (1/64 Pa) and a saturation flag.
//   A transaction passes from input accept to out_valid through four front
//   stages (temperature and coefficient products), three Horner steps of five
//   stages each (32x32 partial-product multipliers) and one output register.
//   Throughput is one transaction per cycle while the receiver does not stall.
//   Reset clears all valid bits and the calibration words to zero.
//   When the receiver stalls, stages fill up behind the output register and
//   in_ready drops only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit #(
  parameter int FRAC_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]      paddr,
  input  logic [bpc_pkg::DATA_W-1:0]      pwdata,
  output logic [bpc_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [23:0]                     in_raw_temperature,
  input  logic [23:0]                     in_raw_pressure,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [23:0]              out_temperature_out,
  output logic [22:0]                     out_pressure_out,
  output logic                            out_clipped
);

  localparam int TN_W = 13 + FRAC_BITS;
  localparam int H3_W = 34;
  localparam int H2_W = 47 + FRAC_BITS;
  localparam int H1_W = 60 + 2 * FRAC_BITS;
  localparam int H0_W = 73 + 3 * FRAC_BITS;
  localparam int RES_SH = 31 + 3 * FRAC_BITS;
  localparam int RES_W = H0_W - RES_SH;
  localparam int C1_W = 63;
  localparam int C0_W = 89;
  localparam int SB3_W = 25 + C1_W + C0_W;
  localparam int SB2_W = 25 + C0_W;
  localparam int SB1_W = 25;
  localparam int NF = 4;

  // Configuration registers
  logic [63:0] cal_lo_r;
  logic [63:0] cal_mid_r;
  logic [bpc_pkg::CAL_HI_W-1:0] cal_hi_r;
  logic [bpc_pkg::CAL_W-1:0] cal;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_lo_r  <= '0;
      cal_mid_r <= '0;
      cal_hi_r  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (bpc_pkg::reg_sel_t'(paddr[4:3]))
        bpc_pkg::REG_LO:  cal_lo_r  <= pwdata;
        bpc_pkg::REG_MID: cal_mid_r <= pwdata;
        bpc_pkg::REG_HI:  cal_hi_r  <= pwdata[bpc_pkg::CAL_HI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bpc_pkg::reg_sel_t'(paddr[4:3]))
      bpc_pkg::REG_LO:  prdata = cal_lo_r;
      bpc_pkg::REG_MID: prdata = cal_mid_r;
      bpc_pkg::REG_HI:  prdata = bpc_pkg::DATA_W'(cal_hi_r);
      default:          prdata = '0;
    endcase
  end

  assign cal = {cal_hi_r, cal_mid_r, cal_lo_r};

  logic [15:0]        t1_u, t2_u, p5_u, p6_u;
  logic signed [7:0]  t3_s, p3_s, p4_s, p7_s, p8_s, p10_s, p11_s;
  logic signed [15:0] p1_s, p2_s, p9_s;

  assign t1_u  = cal[15:0];
  assign t2_u  = cal[31:16];
  assign t3_s  = $signed(cal[39:32]);
  assign p1_s  = $signed(cal[55:40]);
  assign p2_s  = $signed(cal[71:56]);
  assign p3_s  = $signed(cal[79:72]);
  assign p4_s  = $signed(cal[87:80]);
  assign p5_u  = cal[103:88];
  assign p6_u  = cal[119:104];
  assign p7_s  = $signed(cal[127:120]);
  assign p8_s  = $signed(cal[135:128]);
  assign p9_s  = $signed(cal[151:136]);
  assign p10_s = $signed(cal[159:152]);
  assign p11_s = $signed(cal[167:160]);

  // Front stage handshake
  logic [NF-1:0] fv_r;
  logic [NF-1:0] fen;
  logic          st3_in_ready;

  always_comb begin
    fen[NF-1] = !fv_r[NF-1] || st3_in_ready;
    for (int k = NF - 2; k >= 0; k--) begin
      fen[k] = !fv_r[k] || fen[k+1];
    end
  end

  assign in_ready = fen[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      if (fen[0]) begin
        fv_r[0] <= in_valid;
      end
      for (int k = 1; k < NF; k++) begin
        if (fen[k]) begin
          fv_r[k] <= fv_r[k-1];
        end
      end
    end
  end

  // Stage 0: temperature offset and coefficient-by-pressure products
  logic signed [24:0] pz0;
  logic signed [16:0] p1m, p2m;
  logic signed [25:0] d_r;
  logic [23:0]        press0_r;
  logic signed [32:0] p4p_r, p3p_r, p10p_r, p11p_r;
  logic signed [41:0] p2p_r, p1p_r;
  logic signed [40:0] p9p_r;

  assign pz0 = $signed({1'b0, in_raw_pressure});
  assign p1m = $signed({p1_s[15], p1_s}) - 17'sd16384;
  assign p2m = $signed({p2_s[15], p2_s}) - 17'sd16384;

  always_ff @(posedge clk) begin
    if (fen[0]) begin
      d_r      <= $signed({2'b00, in_raw_temperature}) - $signed({2'b00, t1_u, 8'h00});
      press0_r <= in_raw_pressure;
      p4p_r    <= p4_s * pz0;
      p3p_r    <= p3_s * pz0;
      p10p_r   <= p10_s * pz0;
      p11p_r   <= p11_s * pz0;
      p2p_r    <= p2m * pz0;
      p1p_r    <= p1m * pz0;
      p9p_r    <= p9_s * pz0;
    end
  end

  // Stage 1: second-order products
  logic signed [24:0] pz1;
  logic signed [41:0] dt2_r;
  logic signed [51:0] dd_r;
  logic signed [57:0] p10pp_r, p11pp_r;
  logic signed [65:0] p9pp_r;
  logic signed [33:0] b3_r, c2_r;
  logic [23:0]        press1_r;
  logic signed [41:0] p2pb_r, p1pb_r;

  assign pz1 = $signed({1'b0, press0_r});

  always_ff @(posedge clk) begin
    if (fen[1]) begin
      dt2_r    <= d_r * $signed({1'b0, t2_u});
      dd_r     <= d_r * d_r;
      p10pp_r  <= p10p_r * pz1;
      p11pp_r  <= p11p_r * pz1;
      p9pp_r   <= p9p_r * pz1;
      b3_r     <= (34'(p8_s) <<< 22) + 34'(p4p_r);
      c2_r     <= (34'(p7_s) <<< 24) + 34'(p3p_r);
      press1_r <= press0_r;
      p2pb_r   <= p2p_r;
      p1pb_r   <= p1p_r;
    end
  end

  // Stage 2: scaled temperature and coefficient groups
  logic signed [24:0] pz2;
  logic signed [60:0] s_r;
  logic signed [82:0] p11ppp_r;
  logic signed [C1_W-1:0] c1_r;
  logic signed [C0_W-1:0] c0a_r;
  logic signed [33:0] b3b_r, c2b_r;

  assign pz2 = $signed({1'b0, press1_r});

  always_ff @(posedge clk) begin
    if (fen[2]) begin
      s_r      <= (61'(dt2_r) <<< 18) + 61'(dd_r * 61'(t3_s));
      p11ppp_r <= p11pp_r * pz2;
      c1_r     <= (C1_W'($signed({1'b0, p6_u})) <<< 42) + (C1_W'(p2pb_r) <<< 19)
                  + C1_W'(p10pp_r);
      c0a_r    <= (C0_W'($signed({1'b0, p5_u})) <<< 68) + (C0_W'(p1pb_r) <<< 45)
                  + (C0_W'(p9pp_r) <<< 17);
      b3b_r    <= b3_r;
      c2b_r    <= c2_r;
    end
  end

  // Stage 3: temperature outputs and constant group
  logic signed [60:0] tq_full;
  logic signed [23:0] tq_nxt;
  logic               tclip_nxt;
  logic signed [TN_W-1:0] tn_r;
  logic signed [23:0] tq_r;
  logic               tclip_r;
  logic signed [C0_W-1:0] c0_r;
  logic signed [C1_W-1:0] c1b_r;
  logic signed [33:0] b3c_r, c2c_r;

  assign tq_full = s_r >>> 32;

  always_comb begin
    if (tq_full > 61'(bpc_pkg::T_MAX)) begin
      tq_nxt    = bpc_pkg::T_MAX;
      tclip_nxt = 1'b1;
    end else if (tq_full < 61'(bpc_pkg::T_MIN)) begin
      tq_nxt    = bpc_pkg::T_MIN;
      tclip_nxt = 1'b1;
    end else begin
      tq_nxt    = tq_full[23:0];
      tclip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fen[3]) begin
      tn_r    <= TN_W'(s_r >>> (48 - FRAC_BITS));
      tq_r    <= tq_nxt;
      tclip_r <= tclip_nxt;
      c0_r    <= c0a_r + C0_W'(p11ppp_r);
      c1b_r   <= c1_r;
      b3c_r   <= b3b_r;
      c2c_r   <= c2b_r;
    end
  end

  // Horner steps
  logic                   st3_valid, st2_ready, st2_valid, st1_ready, st1_valid;
  logic                   o_en;
  logic signed [TN_W-1:0] st3_tn, st2_tn;
  logic signed [H2_W-1:0] st3_h;
  logic signed [H1_W-1:0] st2_h;
  logic signed [H0_W-1:0] st1_h;
  logic [SB3_W-1:0]       st3_sb;
  logic [SB2_W-1:0]       st2_sb;
  logic [SB1_W-1:0]       st1_sb;

  bpc_hstep #(
    .TN_W(TN_W), .HI_W(H3_W), .HO_W(H2_W), .SB_W(SB3_W)
  ) u_step3 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(fv_r[NF-1]), .in_ready(st3_in_ready),
    .in_tn(tn_r), .in_h(b3c_r),
    .in_b(H2_W'(c2c_r) <<< (5 + FRAC_BITS)),
    .in_sb({tq_r, tclip_r, c1b_r, c0_r}),
    .out_valid(st3_valid), .out_ready(st2_ready),
    .out_tn(st3_tn), .out_h(st3_h), .out_sb(st3_sb)
  );

  bpc_hstep #(
    .TN_W(TN_W), .HI_W(H2_W), .HO_W(H1_W), .SB_W(SB2_W)
  ) u_step2 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(st3_valid), .in_ready(st2_ready),
    .in_tn(st3_tn), .in_h(st3_h),
    .in_b(H1_W'($signed(st3_sb[C0_W +: C1_W])) <<< (2 * FRAC_BITS - 11)),
    .in_sb({st3_sb[SB3_W-1 -: 25], st3_sb[C0_W-1:0]}),
    .out_valid(st2_valid), .out_ready(st1_ready),
    .out_tn(st2_tn), .out_h(st2_h), .out_sb(st2_sb)
  );

  bpc_hstep #(
    .TN_W(TN_W), .HI_W(H1_W), .HO_W(H0_W), .SB_W(SB1_W)
  ) u_step1 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(st2_valid), .in_ready(st1_ready),
    .in_tn(st2_tn), .in_h(st2_h),
    .in_b(H0_W'($signed(st2_sb[C0_W-1:0])) <<< (3 * FRAC_BITS - 28)),
    .in_sb(st2_sb[SB2_W-1 -: 25]),
    .out_valid(st1_valid), .out_ready(o_en),
    .out_tn(), .out_h(st1_h), .out_sb(st1_sb)
  );

  // Output stage: floor shift and pressure saturation
  logic [RES_W-1:0] res;
  logic [22:0]      p_nxt;
  logic             pclip_nxt;
  logic             out_valid_r;
  logic signed [23:0] temp_r;
  logic [22:0]      press_r;
  logic             clip_r;

  assign res = st1_h[H0_W-1:RES_SH];

  always_comb begin
    if (res[RES_W-1]) begin
      p_nxt     = '0;
      pclip_nxt = 1'b1;
    end else if (res > RES_W'(bpc_pkg::P_MAX)) begin
      p_nxt     = bpc_pkg::P_MAX;
      pclip_nxt = 1'b1;
    end else begin
      p_nxt     = res[22:0];
      pclip_nxt = 1'b0;
    end
  end

  assign o_en = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_en) begin
      out_valid_r <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en && st1_valid) begin
      temp_r  <= $signed(st1_sb[24:1]);
      press_r <= p_nxt;
      clip_r  <= st1_sb[0] | pclip_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temperature_out = temp_r;
  assign out_pressure_out    = press_r;
  assign out_clipped         = clip_r;

`ifndef ASSERT_OFF
  a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output not blocked");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_clip_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_temperature_out != bpc_pkg::T_MAX
     && out_temperature_out != bpc_pkg::T_MIN
     && out_pressure_out != 23'd0 && out_pressure_out != bpc_pkg::P_MAX)
    |-> !out_clipped)
    else $error("clip flag set with both results inside range");
`endif

endmodule
